// ===== rtl/core/first_fit_unit_allocator_macros.svh =====
`ifndef FIRST_FIT_UNIT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define FFUA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, checked outside reset
`define FFUA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== rtl/core/ffua_pkg.sv =====
package ffua_pkg;

    localparam int OWNER_ID_W = 10;
    localparam int SIZE_W     = 11;
    localparam int START_W    = 10;
    localparam int FREED_W    = 11;
    localparam int POOL_W     = 11;

    localparam int DEF_MAX_UNITS  = 1024;
    localparam int DEF_OWNER_BITS = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [SIZE_W-1:0]     request_size;
        logic [OWNER_ID_W-1:0] owner_id;
    } t_request;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] start_unit;
        logic [FREED_W-1:0] freed_units;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic reject;
        logic clear;
        logic scan;
        logic fill;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_free;
        logic req_ok;
        logic found;
        logic scan_done;
        logic fill_last;
        logic clear_last;
    } t_status;

endpackage

// ===== rtl/core/first_fit_unit_allocator.sv =====
// First-fit unit allocator over a pool of equal units, one owner tag per unit.
// Request channel: drive i_req and raise start; the item is taken on a clock
// edge where start is high and busy is low. Allocate claims the lowest run of
// free units at least request_size long and tags its first request_size units;
// free releases every unit carrying the owner tag and reports how many.
// Result channel: o_result is shown for one cycle with o_result_valid high.
// The receiver cannot hold it off; the block never waits on the output side.
// Work per item, from the accepting edge to the edge that takes the result:
//   allocate rejected up front (size 0, size above pool, owner 0): no table pass, result registered.
//   allocate: scan of up to pool units (capped at MAX_UNITS), fill of request_size units if found, then the result.
//   free: every one of the MAX_UNITS table entries is read and matched, then the result.
// One item at a time: busy falls as the result shows, so the next item can be
// taken at the edge that takes the result.
// All cost comes from the owner table, a single-port-write, single-read RAM
// walked one unit per cycle with a registered read.
// Reset runs a clearing pass over all MAX_UNITS entries with busy high; pool_units
// (i_cfg_we / i_cfg_wdata) may be written during it and whenever idle.
`include "first_fit_unit_allocator_macros.svh"

module first_fit_unit_allocator
    import ffua_pkg::*;
#(
    parameter int MAX_UNITS  = DEF_MAX_UNITS,
    parameter int OWNER_BITS = DEF_OWNER_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_request          i_req,
    input  logic              i_cfg_we,
    input  logic [POOL_W-1:0] i_cfg_wdata,
    output t_result           o_result,
    output logic              o_result_valid
);

    t_cmd    w_cmd;
    t_status w_status;

    ffua_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    ffua_datapath #(
        .MAX_UNITS  (MAX_UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (w_status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // a started scan keeps the block busy
    `FFUA_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, w_cmd.load && !w_cmd.reject, busy)
    // every finished item shows a result in the next cycle
    `FFUA_ASSERT_NEXT(a_finish_result, i_clk, i_rst_n, w_cmd.finish || w_cmd.reject, o_result_valid)
    // only one source may own the table write port
    `FFUA_ASSERT_NOW(a_write_excl, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.clear, w_cmd.scan, w_cmd.fill}))
    // released units only come with a successful item
    `FFUA_ASSERT_NOW(a_freed_ok, i_clk, i_rst_n, o_result_valid && (o_result.freed_units != '0), o_result.success)

endmodule

// ===== rtl/core/ffua_ctrl.sv =====
module ffua_ctrl
    import ffua_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FILL  = 5'b01000,
        S_FREE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_status.req_free) begin
                        n_state = S_FREE;
                    end else if (i_status.req_ok) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.reject = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.found) begin
                    n_state = S_FILL;
                end else if (i_status.scan_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_status.fill_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FREE: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/core/ffua_datapath.sv =====
module ffua_datapath
    import ffua_pkg::*;
#(
    parameter int MAX_UNITS  = DEF_MAX_UNITS,
    parameter int OWNER_BITS = DEF_OWNER_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_request          i_req,
    input  logic              i_cfg_we,
    input  logic [POOL_W-1:0] i_cfg_wdata,
    output t_status           o_status,
    output t_result           o_result,
    output logic              o_result_valid
);

    localparam int UW = $clog2(MAX_UNITS);
    localparam int CW = $clog2(MAX_UNITS + 1);
    localparam int PW = (CW > POOL_W) ? CW : POOL_W;

    logic [OWNER_BITS-1:0] r_mem [MAX_UNITS];
    logic [OWNER_BITS-1:0] r_rdata;

    logic [PW-1:0]         r_pool;
    logic [CW-1:0]         r_raddr;
    logic                  r_rvld;
    logic [UW-1:0]         r_caddr;
    logic                  r_found;
    logic                  r_op;
    logic [CW-1:0]         r_size;
    logic [OWNER_BITS-1:0] r_owner;
    logic [CW-1:0]         r_limit;
    logic [CW-1:0]         r_run;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_start;
    logic [UW-1:0]         r_fill;
    t_result               r_res;
    logic                  r_res_vld;

    logic [OWNER_BITS-1:0] w_owner;
    logic [CW-1:0]         w_eff;
    logic [CW-1:0]         w_run_inc;
    logic [CW-1:0]         w_start;
    logic                  w_slot_free;
    logic                  w_hit_alloc;
    logic                  w_hit_free;
    logic                  w_issue;
    logic                  w_we;
    logic [UW-1:0]         w_waddr;
    logic [OWNER_BITS-1:0] w_wdata;

    assign w_owner = OWNER_BITS'(i_req.owner_id);
    assign w_eff   = (32'(r_pool) > 32'(MAX_UNITS)) ? CW'(MAX_UNITS) : CW'(r_pool);

    assign w_slot_free = (r_rdata == '0);
    assign w_run_inc   = r_run + CW'(1);
    assign w_start     = CW'(r_caddr) + CW'(1) - r_size;
    assign w_hit_alloc = r_rvld && (r_op == OP_ALLOC) && w_slot_free && (w_run_inc == r_size);
    assign w_hit_free  = r_rvld && (r_op == OP_FREE) && (r_owner != '0) && (r_rdata == r_owner);
    assign w_issue     = i_cmd.scan && !r_found && !w_hit_alloc && (r_raddr < r_limit);

    // one write port: clearing pass, release on owner match, or run fill
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_raddr[UW-1:0];
        w_wdata = '0;
        priority if (i_cmd.clear) begin
            w_we = 1'b1;
        end else if (w_hit_free) begin
            w_we    = 1'b1;
            w_waddr = r_caddr;
        end else if (i_cmd.fill) begin
            w_we    = 1'b1;
            w_waddr = r_fill;
            w_wdata = r_owner;
        end else begin
            w_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_raddr[UW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool    <= PW'(MAX_UNITS);
            r_raddr   <= '0;
            r_rvld    <= 1'b0;
            r_found   <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pool <= PW'(i_cfg_wdata);
            end
            r_res_vld <= i_cmd.finish || i_cmd.reject;
            if (i_cmd.load) begin
                r_raddr <= '0;
                r_rvld  <= 1'b0;
                r_found <= 1'b0;
            end else begin
                r_rvld <= w_issue;
                if (i_cmd.clear || w_issue) begin
                    r_raddr <= r_raddr + CW'(1);
                end
                if (w_hit_alloc) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_req.operation;
            r_size  <= CW'(i_req.request_size);
            r_owner <= w_owner;
            r_limit <= (i_req.operation == OP_FREE) ? CW'(MAX_UNITS) : w_eff;
            r_run   <= '0;
            r_cnt   <= '0;
        end else begin
            if (w_issue) begin
                r_caddr <= r_raddr[UW-1:0];
            end
            if (r_rvld && (r_op == OP_ALLOC)) begin
                r_run <= w_slot_free ? w_run_inc : '0;
            end
            if (w_hit_free) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (w_hit_alloc) begin
                r_start <= w_start;
                r_fill  <= w_start[UW-1:0];
            end else if (i_cmd.fill) begin
                r_fill <= r_fill + UW'(1);
            end
        end
        if (i_cmd.reject) begin
            r_res <= '0;
        end else if (i_cmd.finish) begin
            r_res.success     <= (r_op == OP_FREE) || r_found;
            r_res.start_unit  <= ((r_op == OP_ALLOC) && r_found) ? START_W'(r_start) : '0;
            r_res.freed_units <= (r_op == OP_FREE) ? FREED_W'(r_cnt) : '0;
        end
    end

    assign o_status.req_free   = (i_req.operation == OP_FREE);
    assign o_status.req_ok     = (w_owner != '0) && (i_req.request_size != '0)
                                 && (32'(i_req.request_size) <= 32'(w_eff));
    assign o_status.found      = r_found;
    assign o_status.scan_done  = !r_found && !r_rvld && !(r_raddr < r_limit);
    assign o_status.fill_last  = (r_fill == r_caddr);
    assign o_status.clear_last = (r_raddr == CW'(MAX_UNITS - 1));

    assign o_result       = r_res;
    assign o_result_valid = r_res_vld;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import ffua_pkg::*;
();

    typedef struct {
        logic              is_cfg;
        logic [POOL_W-1:0] pool_value;
        t_request          req;
        logic              steady;
    } t_job;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_request          i_req       = '0;
    logic              i_cfg_we    = 1'b0;
    logic [POOL_W-1:0] i_cfg_wdata = '0;
    t_result           o_result;
    logic              o_result_valid;

    // shadow of the allocator state
    logic [OWNER_ID_W-1:0] unit_owner [DEF_MAX_UNITS];
    logic [POOL_W-1:0]     pool_reg;

    t_job    job_queue[$];
    t_result outcome_queue[$];
    t_job    cur_job;
    int      idle_left      = 0;
    int      accepted_items = 0;
    int      checked_results = 0;
    int      cfg_writes     = 0;
    int      error_count    = 0;

    first_fit_unit_allocator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result predict_outcome(t_request r);
        t_result res;
        int      eff;
        int      run;
        int      count;
        int      i;
        int      k;
        res = '0;
        if (r.operation == OP_FREE) begin
            count = 0;
            if (r.owner_id != '0) begin
                for (i = 0; i < DEF_MAX_UNITS; i++) begin
                    if (unit_owner[i] == r.owner_id) begin
                        unit_owner[i] = '0;
                        count++;
                    end
                end
            end
            res.success     = 1'b1;
            res.freed_units = count[FREED_W-1:0];
            return res;
        end
        eff = (pool_reg > DEF_MAX_UNITS) ? DEF_MAX_UNITS : int'(pool_reg);
        if (r.owner_id == '0 || r.request_size == '0 || r.request_size > eff)
            return res;
        run = 0;
        for (i = 0; i < eff; i++) begin
            if (unit_owner[i] == '0) begin
                run++;
                if (run == r.request_size) begin
                    for (k = i + 1 - run; k <= i; k++)
                        unit_owner[k] = r.owner_id;
                    res.success    = 1'b1;
                    res.start_unit = START_W'(i + 1 - run);
                    return res;
                end
            end else begin
                run = 0;
            end
        end
        return res;
    endfunction

    task automatic queue_job(input t_job j);
        job_queue = {job_queue, j};
    endtask

    task automatic push_alloc(input int size, input int owner, input logic steady);
        t_job j;
        j.is_cfg           = 1'b0;
        j.pool_value       = '0;
        j.req.operation    = OP_ALLOC;
        j.req.request_size = SIZE_W'(size);
        j.req.owner_id     = OWNER_ID_W'(owner);
        j.steady           = steady;
        queue_job(j);
    endtask

    task automatic push_free(input int owner, input logic steady);
        t_job j;
        j.is_cfg           = 1'b0;
        j.pool_value       = '0;
        j.req.operation    = OP_FREE;
        j.req.request_size = SIZE_W'($urandom_range(0, 2047));
        j.req.owner_id     = OWNER_ID_W'(owner);
        j.steady           = steady;
        queue_job(j);
    endtask

    task automatic push_pool(input int value);
        t_job j;
        j.is_cfg     = 1'b1;
        j.pool_value = POOL_W'(value);
        j.req        = '0;
        j.steady     = 1'b0;
        queue_job(j);
    endtask

    task automatic add_random_phase(input int pool, input int n, input logic steady);
        int eff;
        int span;
        int i;
        int pick;
        int sz;
        int own;
        push_pool(pool);
        eff  = (pool > DEF_MAX_UNITS) ? DEF_MAX_UNITS : pool;
        span = (eff < 4) ? 1 : eff / 4;
        for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            // a small owner set keeps frees effective; some wide owners as noise
            own = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 12);
            if (pick < 30) begin
                push_free(own, steady);
            end else begin
                if (pick < 85)
                    sz = $urandom_range(1, span);
                else if (pick < 92)
                    sz = $urandom_range(0, 2047);
                else
                    sz = eff + $urandom_range(0, 1);
                push_alloc(sz, own, steady);
            end
        end
    endtask

    always @(posedge i_clk) begin : drive
        logic next_start;
        logic next_we;
        t_job job;
        next_start = start;
        next_we    = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                outcome_queue = {outcome_queue, predict_outcome(cur_job.req)};
                accepted_items++;
                next_start = 1'b0;
                if (!cur_job.steady && $urandom_range(0, 2) == 0)
                    idle_left = $urandom_range(1, 18);
            end
            if (!next_start && job_queue.size() != 0) begin
                if (idle_left != 0) begin
                    idle_left--;
                end else if (job_queue[0].is_cfg) begin
                    // pool changes only with nothing in flight
                    if (!busy && o_result_valid !== 1'b1 && outcome_queue.size() == 0) begin
                        job = job_queue.pop_front();
                        pool_reg = job.pool_value;
                        next_we  = 1'b1;
                        i_cfg_wdata <= job.pool_value;
                        cfg_writes++;
                    end
                end else begin
                    cur_job = job_queue.pop_front();
                    i_req <= cur_job.req;
                    next_start = 1'b1;
                end
            end
        end
        start    <= next_start;
        i_cfg_we <= next_we;
    end

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (outcome_queue.size() == 0) begin
                $display("%0t: result with none pending: expected none, actual %p",
                         $time, o_result);
                error_count++;
            end else begin
                want = outcome_queue.pop_front();
                checked_results++;
                if (o_result.success !== want.success ||
                    o_result.start_unit !== want.start_unit ||
                    o_result.freed_units !== want.freed_units) begin
                    $display("%0t: expected success=%0d start=%0d freed=%0d, actual success=%0d start=%0d freed=%0d",
                             $time, want.success, want.start_unit, want.freed_units,
                             o_result.success, o_result.start_unit, o_result.freed_units);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int i;
        for (i = 0; i < DEF_MAX_UNITS; i++)
            unit_owner[i] = '0;
        pool_reg = POOL_W'(DEF_MAX_UNITS);

        // rejections, full-pool runs, exhaustion
        push_pool(DEF_MAX_UNITS);
        push_alloc(0, 5, 1'b0);
        push_alloc(1025, 5, 1'b0);
        push_alloc(2047, 1023, 1'b0);
        push_alloc(10, 0, 1'b0);
        push_alloc(1, 1, 1'b0);
        push_alloc(1024, 2, 1'b0);
        push_alloc(1023, 1023, 1'b0);
        push_free(1, 1'b0);
        push_alloc(1, 3, 1'b0);
        push_free(1023, 1'b0);
        push_alloc(1024, 4, 1'b0);
        push_free(3, 1'b0);
        push_alloc(1024, 4, 1'b0);
        push_free(4, 1'b0);
        push_free(0, 1'b0);
        push_free(77, 1'b0);
        // fragmentation: a hole too short, then one that fits exactly
        push_alloc(3, 10, 1'b0);
        push_alloc(2, 11, 1'b0);
        push_alloc(4, 12, 1'b0);
        push_free(11, 1'b0);
        push_alloc(3, 13, 1'b0);
        push_alloc(2, 14, 1'b0);
        // pool shrunk below held units; free still sees them
        push_pool(4);
        push_alloc(1, 15, 1'b0);
        push_free(12, 1'b0);
        push_pool(0);
        push_alloc(1, 20, 1'b0);
        push_pool(2047);
        push_alloc(1, 21, 1'b0);

        add_random_phase(16, 50, 1'b0);
        add_random_phase(1, 50, 1'b0);
        add_random_phase(2047, 50, 1'b0);
        add_random_phase(0, 30, 1'b0);
        add_random_phase($urandom_range(2, 64), 60, 1'b0);
        add_random_phase(DEF_MAX_UNITS, 50, 1'b0);
        add_random_phase($urandom_range(1, 2047), 60, 1'b0);
        add_random_phase(DEF_MAX_UNITS, 50, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_queue.size() != 0 || start || outcome_queue.size() != 0)
            @(posedge i_clk);
        repeat (DEF_MAX_UNITS + 16) @(posedge i_clk);

        $display("%0d requests issued across %0d pool settings; %0d results checked, %0d errors",
                 accepted_items, cfg_writes, checked_results, error_count);
        if (error_count == 0 && outcome_queue.size() == 0)
            $display("first_fit_unit_allocator: match");
        else
            $display("first_fit_unit_allocator: mismatch");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", outcome_queue.size());
        $display("first_fit_unit_allocator: mismatch");
        $finish;
    end

endmodule

// ===== first_fit_unit_allocator.f =====
+incdir+rtl/core
rtl/core/ffua_pkg.sv
rtl/core/ffua_ctrl.sv
rtl/core/ffua_datapath.sv
rtl/core/first_fit_unit_allocator.sv
sim/testbench.sv
